### hw/rtl/htlp_pkg.sv
// Shared constants, codes and controller/datapath interface types of the hash table
`default_nettype none
package htlp_pkg;

	// Table geometry; the slot count is a power of two so that home = key mod SLOTS
	localparam int SLOTS = 16;
	localparam int AW    = $clog2(SLOTS);

	// Field widths
	localparam int KW  = 34;
	localparam int N0W = 64;
	localparam int N1W = 64;
	localparam int N2W = 24;
	localparam int RW  = 2;
	localparam int SW  = 3;
	localparam int PW  = 4;

	// Name payload of a slot that has never been written
	localparam logic [N0W-1:0] NAME_LOW_RST = N0W'(45);

	// Request codes
	localparam logic [RW-1:0] REQ_INS  = RW'(0);
	localparam logic [RW-1:0] REQ_REPL = RW'(1);
	localparam logic [RW-1:0] REQ_READ = RW'(2);
	localparam logic [RW-1:0] REQ_BAD  = RW'(3);

	// Result status codes
	localparam logic [SW-1:0] ST_HOME    = SW'(0);
	localparam logic [SW-1:0] ST_PROBED  = SW'(1);
	localparam logic [SW-1:0] ST_DISPL   = SW'(2);
	localparam logic [SW-1:0] ST_FULL    = SW'(3);
	localparam logic [SW-1:0] ST_INVALID = SW'(4);
	localparam logic [SW-1:0] ST_READ    = SW'(5);

	// Commands from controller to datapath
	typedef struct packed {
		logic          load;     // capture the accepted request
		logic [AW-1:0] addr;     // slot addressed this cycle
		logic          wr_new;   // write request entry at addr, clear its link
		logic          set_link; // set link of addr to link_to
		logic [AW-1:0] link_to;
		logic          cap_tmp;  // capture entry at addr for a move
		logic          wr_move;  // write captured entry to addr
		logic          name_rd;  // read name memory at addr
		logic          cap_out;  // capture result from addr
		logic [SW-1:0] status;
		logic          show;
	} dp_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic [RW-1:0] req_type;
		logic          key_in_zero;
		logic [AW-1:0] home;
		logic [AW-1:0] read_slot;
		logic          key_zero;   // slot at addr is empty
		logic          home_match; // occupant of addr hashes to home
		logic          link_valid; // slot at addr has a link
		logic          link_home;  // link of addr points at home
	} dp_stat_t;

endpackage
`default_nettype wire

### hw/rtl/hash_table_linear_probe_chained.sv
// Top level of the linear-probing hash table with chaining and replacement
//
// Use: one request transaction on the in channel gives exactly one result
// transaction on the out channel. Requests insert a key with its 19-byte name
// (with or without displacing a foreign occupant of the home slot) or read
// one slot. The block works on one transaction at a time: in_ready is high
// only while it is idle, and the result is held in output registers.
// After acceptance, a read, an invalid key or a placement at home goes
// straight to the result; a probed insert searches for the first empty slot,
// then for the chain tail to link to it; an insert with displacement moves
// the foreign occupant of home to the first empty slot, writes home, then
// searches for the predecessor linked to home. Searches visit at most SLOTS
// slots, one slot per cycle through the single slot read port.
// Reset empties every slot and clears every link at once; no clearing pass.
// When the receiver stalls, the result is held and no new request is taken
// until it has been accepted.
`default_nettype none
module hash_table_linear_probe_chained (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic [htlp_pkg::RW-1:0]  req_type,
	input  wire logic [htlp_pkg::KW-1:0]  key,
	input  wire logic [htlp_pkg::N0W-1:0] name_part0,
	input  wire logic [htlp_pkg::N1W-1:0] name_part1,
	input  wire logic [htlp_pkg::N2W-1:0] name_part2,
	input  wire logic [htlp_pkg::PW-1:0]  read_slot,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic [htlp_pkg::SW-1:0]       status,
	output logic [htlp_pkg::PW-1:0]       slot_index,
	output logic [htlp_pkg::KW-1:0]       entry_key,
	output logic [htlp_pkg::N0W-1:0]      entry_name0,
	output logic [htlp_pkg::N1W-1:0]      entry_name1,
	output logic [htlp_pkg::N2W-1:0]      entry_name2,
	output logic                          link_present,
	output logic [htlp_pkg::PW-1:0]       link_target
);

	htlp_pkg::dp_cmd_t  cmd;
	htlp_pkg::dp_stat_t stat;

	// Sequencer
	htlp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Storage and result registers
	htlp_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.req_type     (req_type),
		.key          (key),
		.name_part0   (name_part0),
		.name_part1   (name_part1),
		.name_part2   (name_part2),
		.read_slot    (read_slot),
		.status       (status),
		.slot_index   (slot_index),
		.entry_key    (entry_key),
		.entry_name0  (entry_name0),
		.entry_name1  (entry_name1),
		.entry_name2  (entry_name2),
		.link_present (link_present),
		.link_target  (link_target)
	);

endmodule
`default_nettype wire

### hw/rtl/htlp_dp.sv
// Datapath of the hash table: slot storage, name memory, request and result registers
`default_nettype none
module htlp_dp (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire htlp_pkg::dp_cmd_t           cmd,
	output htlp_pkg::dp_stat_t               stat,
	input  wire logic [htlp_pkg::RW-1:0]     req_type,
	input  wire logic [htlp_pkg::KW-1:0]     key,
	input  wire logic [htlp_pkg::N0W-1:0]    name_part0,
	input  wire logic [htlp_pkg::N1W-1:0]    name_part1,
	input  wire logic [htlp_pkg::N2W-1:0]    name_part2,
	input  wire logic [htlp_pkg::PW-1:0]     read_slot,
	output logic [htlp_pkg::SW-1:0]          status,
	output logic [htlp_pkg::PW-1:0]          slot_index,
	output logic [htlp_pkg::KW-1:0]          entry_key,
	output logic [htlp_pkg::N0W-1:0]         entry_name0,
	output logic [htlp_pkg::N1W-1:0]         entry_name1,
	output logic [htlp_pkg::N2W-1:0]         entry_name2,
	output logic                             link_present,
	output logic [htlp_pkg::PW-1:0]          link_target
);

	localparam int NMW = htlp_pkg::N0W + htlp_pkg::N1W + htlp_pkg::N2W;

	// Request registers
	logic [htlp_pkg::RW-1:0]  req_q;
	logic [htlp_pkg::KW-1:0]  key_q;
	logic [NMW-1:0]           name_q;
	logic [htlp_pkg::AW-1:0]  rs_q;

	// Slot storage in flops, one combinational read port at cmd.addr
	logic [htlp_pkg::KW-1:0]  key_st_q [htlp_pkg::SLOTS];
	logic                     lv_st_q  [htlp_pkg::SLOTS];
	logic [htlp_pkg::AW-1:0]  li_st_q  [htlp_pkg::SLOTS];
	logic                     nv_st_q  [htlp_pkg::SLOTS];

	// Name memory, registered read
	logic [NMW-1:0]           name_mem [htlp_pkg::SLOTS];
	logic [NMW-1:0]           nrd_q;

	// Move buffer
	logic [htlp_pkg::KW-1:0]  tkey_q;
	logic                     tlv_q;
	logic [htlp_pkg::AW-1:0]  tli_q;
	logic                     tnv_q;

	// Result registers
	logic [htlp_pkg::SW-1:0]  o_status_q;
	logic                     o_show_q;
	logic [htlp_pkg::AW-1:0]  o_slot_q;
	logic [htlp_pkg::KW-1:0]  o_key_q;
	logic                     o_lv_q;
	logic [htlp_pkg::AW-1:0]  o_li_q;
	logic                     o_nv_q;

	logic [htlp_pkg::AW-1:0]  home;
	logic [htlp_pkg::KW-1:0]  rd_key;

	assign home   = key_q[htlp_pkg::AW-1:0];
	assign rd_key = key_st_q[cmd.addr];

	// Report to controller
	always_comb begin
		stat.req_type    = req_q;
		stat.key_in_zero = (key_q == '0);
		stat.home        = home;
		stat.read_slot   = rs_q;
		stat.key_zero    = (rd_key == '0);
		stat.home_match  = (rd_key[htlp_pkg::AW-1:0] == home);
		stat.link_valid  = lv_st_q[cmd.addr];
		stat.link_home   = (li_st_q[cmd.addr] == home);
	end

	// Capture request
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q  <= req_type;
			key_q  <= key;
			name_q <= {name_part2, name_part1, name_part0};
			rs_q   <= read_slot[htlp_pkg::AW-1:0];
		end
	end

	// Slot keys, links and name-written marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < htlp_pkg::SLOTS; i++) begin
				key_st_q[i] <= '0;
				lv_st_q[i]  <= 1'b0;
				li_st_q[i]  <= '0;
				nv_st_q[i]  <= 1'b0;
			end
		end else begin
			if (cmd.wr_new) begin
				key_st_q[cmd.addr] <= key_q;
				lv_st_q[cmd.addr]  <= 1'b0;
				li_st_q[cmd.addr]  <= '0;
				nv_st_q[cmd.addr]  <= 1'b1;
			end
			if (cmd.wr_move) begin
				key_st_q[cmd.addr] <= tkey_q;
				lv_st_q[cmd.addr]  <= tlv_q;
				li_st_q[cmd.addr]  <= tli_q;
				nv_st_q[cmd.addr]  <= tnv_q;
			end
			if (cmd.set_link) begin
				lv_st_q[cmd.addr] <= 1'b1;
				li_st_q[cmd.addr] <= cmd.link_to;
			end
		end
	end

	// Name memory port
	always_ff @(posedge clk) begin
		if (cmd.wr_new) begin
			name_mem[cmd.addr] <= name_q;
		end else if (cmd.wr_move) begin
			name_mem[cmd.addr] <= nrd_q;
		end
		if (cmd.name_rd) begin
			nrd_q <= name_mem[cmd.addr];
		end
	end

	// Hold the entry being moved
	always_ff @(posedge clk) begin
		if (cmd.cap_tmp) begin
			tkey_q <= rd_key;
			tlv_q  <= lv_st_q[cmd.addr];
			tli_q  <= li_st_q[cmd.addr];
			tnv_q  <= nv_st_q[cmd.addr];
		end
	end

	// Capture result
	always_ff @(posedge clk) begin
		if (cmd.cap_out) begin
			o_status_q <= cmd.status;
			o_show_q   <= cmd.show;
			o_slot_q   <= cmd.addr;
			o_key_q    <= rd_key;
			o_lv_q     <= lv_st_q[cmd.addr];
			o_li_q     <= li_st_q[cmd.addr];
			o_nv_q     <= nv_st_q[cmd.addr];
		end
	end

	// Drive result fields; hidden fields read as zero, unwritten names as reset
	always_comb begin
		status       = o_status_q;
		slot_index   = '0;
		entry_key    = '0;
		entry_name0  = '0;
		entry_name1  = '0;
		entry_name2  = '0;
		link_present = 1'b0;
		link_target  = '0;
		if (o_show_q) begin
			slot_index   = htlp_pkg::PW'(o_slot_q);
			entry_key    = o_key_q;
			link_present = o_lv_q;
			link_target  = o_lv_q ? htlp_pkg::PW'(o_li_q) : '0;
			if (o_nv_q) begin
				entry_name0 = nrd_q[htlp_pkg::N0W-1:0];
				entry_name1 = nrd_q[htlp_pkg::N0W +: htlp_pkg::N1W];
				entry_name2 = nrd_q[htlp_pkg::N0W+htlp_pkg::N1W +: htlp_pkg::N2W];
			end else begin
				entry_name0 = htlp_pkg::NAME_LOW_RST;
			end
		end
	end

endmodule
`default_nettype wire

### hw/rtl/htlp_ctrl.sv
// Controller of the hash table: probe, chain, move and result sequencing
`default_nettype none
module htlp_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire htlp_pkg::dp_stat_t stat,
	output htlp_pkg::dp_cmd_t      cmd
);

	typedef enum logic [3:0] {
		S_IDLE, S_DEC, S_FIND, S_LINK, S_MVRD, S_MVWR, S_WRH, S_PRED, S_CAP, S_OUT
	} state_t;

	state_t                   state_q;
	logic                     repl_q;
	logic [htlp_pkg::AW-1:0]  ptr_q;
	logic [htlp_pkg::AW-1:0]  cnt_q;
	logic [htlp_pkg::AW-1:0]  e_q;
	logic [htlp_pkg::AW-1:0]  slot_q;
	logic [htlp_pkg::SW-1:0]  st_q;
	logic                     show_q;

	logic link_hit;
	logic last_step;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	assign link_hit  = (ptr_q != e_q) && !stat.key_zero && stat.home_match &&
		!stat.link_valid;
	assign last_step = (cnt_q == htlp_pkg::AW'(htlp_pkg::SLOTS - 1));

	// Commands for the current state
	always_comb begin
		cmd = '0;
		cmd.link_to = e_q;
		cmd.status  = st_q;
		cmd.show    = show_q;
		case (state_q)
			S_IDLE: begin
				cmd.load = in_valid;
			end
			S_DEC: begin
				cmd.addr   = stat.home;
				cmd.wr_new = (stat.req_type == htlp_pkg::REQ_INS ||
					stat.req_type == htlp_pkg::REQ_REPL) && !stat.key_in_zero &&
					stat.key_zero;
			end
			S_FIND: begin
				cmd.addr   = ptr_q;
				cmd.wr_new = (ptr_q != stat.home) && stat.key_zero && !repl_q;
			end
			S_LINK: begin
				cmd.addr     = ptr_q;
				cmd.set_link = link_hit;
			end
			S_MVRD: begin
				cmd.addr    = stat.home;
				cmd.cap_tmp = 1'b1;
				cmd.name_rd = 1'b1;
			end
			S_MVWR: begin
				cmd.addr    = e_q;
				cmd.wr_move = 1'b1;
			end
			S_WRH: begin
				cmd.addr   = stat.home;
				cmd.wr_new = 1'b1;
			end
			S_PRED: begin
				cmd.addr     = ptr_q;
				cmd.set_link = stat.link_valid && stat.link_home;
			end
			S_CAP: begin
				cmd.addr    = slot_q;
				cmd.cap_out = 1'b1;
				cmd.name_rd = 1'b1;
			end
			default: begin
				cmd.addr = slot_q;
			end
		endcase
	end

	// Sequence one transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			repl_q  <= 1'b0;
			ptr_q   <= '0;
			cnt_q   <= '0;
			e_q     <= '0;
			slot_q  <= '0;
			st_q    <= htlp_pkg::ST_INVALID;
			show_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					show_q <= 1'b1;
					if (stat.req_type == htlp_pkg::REQ_READ) begin
						slot_q  <= stat.read_slot;
						st_q    <= htlp_pkg::ST_READ;
						state_q <= S_CAP;
					end else if (stat.req_type == htlp_pkg::REQ_BAD || stat.key_in_zero) begin
						slot_q  <= '0;
						st_q    <= htlp_pkg::ST_INVALID;
						show_q  <= 1'b0;
						state_q <= S_CAP;
					end else if (stat.key_zero) begin
						slot_q  <= stat.home;
						st_q    <= htlp_pkg::ST_HOME;
						state_q <= S_CAP;
					end else begin
						repl_q  <= (stat.req_type == htlp_pkg::REQ_REPL) && !stat.home_match;
						ptr_q   <= stat.home + 1'b1;
						state_q <= S_FIND;
					end
				end
				S_FIND: begin
					if (ptr_q == stat.home) begin
						slot_q  <= '0;
						st_q    <= htlp_pkg::ST_FULL;
						show_q  <= 1'b0;
						state_q <= S_CAP;
					end else if (stat.key_zero) begin
						e_q <= ptr_q;
						if (repl_q) begin
							state_q <= S_MVRD;
						end else begin
							ptr_q   <= stat.home;
							cnt_q   <= '0;
							state_q <= S_LINK;
						end
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				S_LINK: begin
					slot_q <= e_q;
					st_q   <= htlp_pkg::ST_PROBED;
					if (link_hit || last_step) begin
						state_q <= S_CAP;
					end else begin
						ptr_q <= ptr_q + 1'b1;
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_MVRD: begin
					state_q <= S_MVWR;
				end
				S_MVWR: begin
					state_q <= S_WRH;
				end
				S_WRH: begin
					ptr_q   <= '0;
					slot_q  <= stat.home;
					st_q    <= htlp_pkg::ST_DISPL;
					state_q <= S_PRED;
				end
				S_PRED: begin
					if ((stat.link_valid && stat.link_home) ||
						ptr_q == htlp_pkg::AW'(htlp_pkg::SLOTS - 1)) begin
						state_q <= S_CAP;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				S_CAP: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

### hw/rtl/htlp_chk.sv
// Port-level checker of the hash table and its bind to the top level
`default_nettype none
module htlp_chk (
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     in_valid,
	input wire logic                     in_ready,
	input wire logic                     out_valid,
	input wire logic                     out_ready,
	input wire logic [htlp_pkg::SW-1:0]  status,
	input wire logic [htlp_pkg::KW-1:0]  entry_key,
	input wire logic                     link_present,
	input wire logic [htlp_pkg::PW-1:0]  link_target
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(entry_key))
		else $error("result changed while stalled");

	// Only one transaction in flight
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("request taken while result pending");

	// Full and invalid results carry no entry
	a_reject_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == htlp_pkg::ST_FULL || status == htlp_pkg::ST_INVALID)
		|-> entry_key == '0 && !link_present)
		else $error("rejected request reports an entry");

	// No link target without a link
	a_link_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !link_present |-> link_target == '0)
		else $error("link target without link");

endmodule

bind hash_table_linear_probe_chained htlp_chk u_htlp_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.status       (status),
	.entry_key    (entry_key),
	.link_present (link_present),
	.link_target  (link_target)
);
`default_nettype wire
